### rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants for the compacting block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package cba_pkg;

	localparam int MAX_BYTES  = 65536;
	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);

	localparam int PC_RESET  = 16;
	localparam int PS_RESET  = 4096;
	localparam int CAP_RESET = PC_RESET * PS_RESET;
	localparam bit CAP_OK_RESET = (CAP_RESET <= MAX_BYTES);

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_READ  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD     = 3'd1;
	localparam logic [2:0] ST_NOMEM   = 3'd2;
	localparam logic [2:0] ST_OOB     = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;

	localparam logic CFG_PAGE_COUNT = 1'b0;
	localparam logic CFG_PAGE_SIZE  = 1'b1;

	typedef struct packed {
		logic [15:0] base;
		logic [16:0] size;
		logic        used;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic clr;
	} cba_ctl_t;

endpackage
`default_nettype wire

### rtl/compacting_block_allocator.sv
// ----------------------------------------------------------------------------
// compacting_block_allocator
// Packed block table held in a ring of cells, walked by one head unit.
// ----------------------------------------------------------------------------
// Bad capacity, zero-length or oversized alloc: no rotation, straight to the result.
// Other items: the ring rotates once through all MAX_BLOCKS = 64 cells, then the
// result is held; one item in flight, next accepted once back in idle.
// Reset: empty table, 16 pages of 4096 bytes, full capacity free.
// A config write reinitializes table and capacity; no item is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module compacting_block_allocator
	import cba_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] address,
	input  wire logic [16:0] length,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [15:0]      base
);

	localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_BLOCKS - 1);

	typedef enum logic [1:0] {S_IDLE, S_ROT, S_HOLD} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] k_q;
	logic             init_q;
	logic             cap_ok_q;
	logic [16:0]      free_q;
	logic [16:0]      pc_q;
	logic [16:0]      ps_q;
	logic             done_q;
	logic             compact_q;
	logic             out_valid_q;

	op_t              op_q;
	logic [15:0]      addr_q;
	logic [16:0]      len_q;
	logic [16:0]      gone_q;
	logic [15:0]      prev_end_q;
	logic [2:0]       res_status_q;
	logic [15:0]      res_base_q;
	logic [2:0]       status_q;
	logic [15:0]      base_q;

	cba_ctl_t         ctl;
	entry_t           cq [MAX_BLOCKS];
	entry_t           tail;
	entry_t           h;
	entry_t           shifted;
	logic [MAX_BLOCKS-1:0] used_vec;

	logic             in_fire;
	logic             cfg_fire;
	logic [33:0]      prod;
	logic             cap_ok;
	logic [17:0]      head_end;
	logic [17:0]      room;
	logic             in_blk;
	logic [16:0]      gone_use;
	logic             set_done;
	logic             set_comp;
	logic             res_load;
	logic [2:0]       r_status;
	logic [15:0]      r_base;
	logic [16:0]      free_nxt;

	// ring of cells
	assign ctl.shift = (state_q == S_ROT);
	assign ctl.clr   = init_q;

	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		entry_t d_i;
		if (i == MAX_BLOCKS - 1) begin : g_tail
			assign d_i = tail;
		end else begin : g_mid
			assign d_i = cq[i+1];
		end
		cba_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (d_i),
			.q      (cq[i])
		);
		assign used_vec[i] = cq[i].used;
	end

	assign h = cq[0];

	// handshakes; a config write takes precedence over a new word
	assign in_ready  = (state_q == S_IDLE) && !init_q && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;

	assign prod   = {17'd0, pc_q} * {17'd0, ps_q};
	assign cap_ok = (pc_q != 17'd0) && (ps_q != 17'd0) && (prod <= 34'(MAX_BYTES));

	// head unit: examines the word leaving cell 0, builds the word entering the tail
	assign head_end = {2'b00, h.base} + {1'b0, h.size};
	assign room     = head_end - {2'b00, addr_q};
	assign in_blk   = ({2'b00, addr_q} >= {2'b00, h.base}) && ({2'b00, addr_q} < head_end);
	assign gone_use = compact_q ? gone_q : h.size;

	always_comb begin
		shifted.base = cq[1].base - gone_use[15:0];
		shifted.size = cq[1].size;
		shifted.used = cq[1].used && (k_q != LAST);
		tail     = h;
		set_done = 1'b0;
		set_comp = 1'b0;
		res_load = 1'b0;
		r_status = ST_OK;
		r_base   = h.base;
		free_nxt = free_q;
		case (op_q)
			OP_ALLOC: begin
				if (!done_q && !h.used) begin
					tail     = '{base: prev_end_q, size: len_q, used: 1'b1};
					set_done = 1'b1;
					res_load = 1'b1;
					r_base   = prev_end_q;
					free_nxt = free_q - len_q;
				end
			end
			OP_FREE: begin
				if (compact_q) begin
					tail = shifted;
				end else if (!done_q && h.used && (h.base == addr_q)) begin
					tail     = shifted;
					set_done = 1'b1;
					set_comp = 1'b1;
					res_load = 1'b1;
					r_base   = addr_q;
					free_nxt = free_q + h.size;
				end else if (!done_q && !h.used) begin
					set_done = 1'b1;
				end
			end
			default: begin
				if (!done_q) begin
					if (!h.used) begin
						set_done = 1'b1;
					end else if (in_blk) begin
						set_done = 1'b1;
						res_load = 1'b1;
						r_status = ({1'b0, len_q} > room) ? ST_OOB : ST_OK;
					end
				end
			end
		endcase
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			init_q      <= 1'b0;
			cap_ok_q    <= CAP_OK_RESET;
			free_q      <= CAP_OK_RESET ? 17'(CAP_RESET) : 17'd0;
			pc_q        <= 17'(PC_RESET);
			ps_q        <= 17'(PS_RESET);
			done_q      <= 1'b0;
			compact_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_HOLD && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire) begin
				if (cfg_index == CFG_PAGE_COUNT) begin
					pc_q <= cfg_data;
				end else begin
					ps_q <= cfg_data;
				end
			end
			init_q <= cfg_fire;
			if (init_q) begin
				cap_ok_q <= cap_ok;
				free_q   <= cap_ok ? prod[16:0] : 17'd0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						k_q       <= '0;
						done_q    <= 1'b0;
						compact_q <= 1'b0;
						if (!cap_ok_q || (op_t'(operation) == OP_ALLOC &&
						    (length == 17'd0 || length > free_q))) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_ROT;
						end
					end
				end
				S_ROT: begin
					free_q <= free_nxt;
					if (set_done) begin
						done_q <= 1'b1;
					end
					if (set_comp) begin
						compact_q <= 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q == LAST) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// word registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q       <= op_t'(operation);
			addr_q     <= address;
			len_q      <= length;
			prev_end_q <= 16'd0;
			res_base_q <= 16'd0;
			if (!cap_ok_q || (op_t'(operation) == OP_ALLOC && length == 17'd0)) begin
				res_status_q <= ST_BAD;
			end else if (op_t'(operation) == OP_ALLOC && length > free_q) begin
				res_status_q <= ST_NOMEM;
			end else begin
				res_status_q <= ST_UNKNOWN;
			end
		end
		if (state_q == S_ROT) begin
			prev_end_q <= head_end[15:0];
			if (set_comp) begin
				gone_q <= h.size;
			end
			if (res_load) begin
				res_status_q <= r_status;
				res_base_q   <= r_base;
			end
		end
		if (state_q == S_HOLD && (!out_valid_q || out_ready)) begin
			status_q <= res_status_q;
			base_q   <= res_base_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign base      = base_q;

`ifndef SYNTHESIS
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= 17'(MAX_BYTES))
		else $error("free byte count above capacity limit");

	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> ((used_vec >> 1) & ~used_vec) == '0)
		else $error("used entries not a prefix in idle");

	a_rot_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT && k_q == LAST) |=> state_q == S_HOLD)
		else $error("rotation did not end after a full turn");

	a_comp_done: assert property (@(posedge clk) disable iff (!arst_n)
		compact_q |-> done_q)
		else $error("compaction without a match");
`endif

endmodule
`default_nettype wire

### rtl/cba_cell.sv
// ----------------------------------------------------------------------------
// cba_cell
// One table slot of the ring; loads its neighbor's word on each shift.
// ----------------------------------------------------------------------------
`default_nettype none
module cba_cell
	import cba_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cba_ctl_t ctl,
	input  wire entry_t   d,
	output entry_t        q
);

	logic        used_q;
	logic [15:0] base_q;
	logic [16:0] size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.clr) begin
			used_q <= 1'b0;
		end else if (ctl.shift) begin
			used_q <= d.used;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			base_q <= d.base;
			size_q <= d.size;
		end
	end

	assign q = '{base: base_q, size: size_q, used: used_q};

endmodule
`default_nettype wire
